FILE: rtl/core/sarw_pkg.sv
package sarw_pkg;

    // Number of endpoints and depth of the anti-replay window.
    localparam int unsigned ENDPOINTS = 2;
    localparam int unsigned WINDOW    = 32;

    // Field widths of a request and of a result.
    localparam int unsigned SEQ_W  = 31;
    localparam int unsigned ACK_W  = 32;
    localparam int unsigned BITS_W = 32;
    localparam int unsigned EP_W   = 1;

    // Width of a bit position inside the window.
    localparam int unsigned SH_W = $clog2(WINDOW);

    localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

    // Highest received value after reset: nothing received yet.
    localparam logic signed [ACK_W-1:0] ACK_NONE = {ACK_W{1'b1}};

    typedef enum logic {
        ACT_SEND    = 1'b0,
        ACT_RECEIVE = 1'b1
    } t_action;

    typedef logic [WINDOW-1:0] t_window;

endpackage

FILE: rtl/core/seq_ack_replay_window_core.sv
// Sequence stamping and sliding-window anti-replay check for a small set of
// endpoints.
//
// Requests arrive on the input channel (i_in_valid / o_in_ready). A send
// request returns the endpoint's next outgoing sequence number, which then
// counts up and sticks at the top of its 31-bit range. A receive request
// checks i_seq_in against the endpoint's window and reports in o_accepted
// whether the number is new. Both kinds report the endpoint's highest received
// sequence and its acknowledgement bitmap.
//
// A request is captured in an input register, evaluated by compares and a
// window shift against the endpoint's state, and the result is held in an
// output register (o_out_valid / i_out_ready). The result is shown once the
// request has passed the input register and then the output register. While
// the receiver takes results, one request per cycle is sustained for any mix
// of endpoints, since state is updated in the same cycle it is read.
//
// Reset clears all sequence counters and bitmaps and sets every highest
// received value to -1. When the receiver stalls, the result holds and the
// input register keeps one further request before o_in_ready drops.
module seq_ack_replay_window_core
    import sarw_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_action,
    input  logic [EP_W-1:0]          i_endpoint,
    input  logic [SEQ_W-1:0]         i_seq_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [SEQ_W-1:0]         o_seq_out,
    output logic signed [ACK_W-1:0]  o_ack_out,
    output logic [BITS_W-1:0]        o_ack_bits_out,
    output logic                     o_accepted
);

    // Input register.
    logic              r_s1_valid;
    t_action           r_action;
    logic [EP_W-1:0]   r_endpoint;
    logic [SEQ_W-1:0]  r_seq_in;

    // Per-endpoint state.
    logic [SEQ_W-1:0]         r_next_seq [ENDPOINTS];
    logic signed [ACK_W-1:0]  r_highest  [ENDPOINTS];
    t_window                  r_bitmap   [ENDPOINTS];

    // Output register.
    logic                     r_out_valid;
    logic [SEQ_W-1:0]         r_seq_out;
    logic signed [ACK_W-1:0]  r_ack_out;
    logic [BITS_W-1:0]        r_ack_bits;
    logic                     r_accepted;

    logic                     w_advance;
    logic                     w_in_take;

    // Evaluation of the request held in the input register.
    logic [SEQ_W-1:0]         w_cur_seq;
    logic signed [ACK_W-1:0]  w_top;
    t_window                  w_bits;
    logic signed [ACK_W-1:0]  w_s;
    logic [ACK_W-1:0]         w_ahead;
    logic [ACK_W-1:0]         w_behind;
    logic [ACK_W-1:0]         w_ahead_m1;
    logic [ACK_W-1:0]         w_behind_m1;
    logic                     w_newer;
    logic                     w_equal;
    logic                     w_mark_hit;
    t_window                  w_old_mark;
    t_window                  w_mark;

    logic [SEQ_W-1:0]         n_next_seq;
    logic signed [ACK_W-1:0]  n_highest;
    t_window                  n_bitmap;
    logic                     n_accepted;
    logic [SEQ_W-1:0]         n_seq_out;

    // The result register frees up when empty or when its result is taken.
    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_advance;
    assign w_in_take  = i_in_valid && o_in_ready;

    assign w_cur_seq = r_next_seq[r_endpoint];
    assign w_top     = r_highest[r_endpoint];
    assign w_bits    = r_bitmap[r_endpoint];
    assign w_s       = $signed({1'b0, r_seq_in});

    // Distance forward from the highest (newer case) and back from it.
    assign w_ahead     = ACK_W'(w_s - w_top);
    assign w_behind    = ACK_W'(w_top - w_s);
    assign w_ahead_m1  = w_ahead - ACK_W'(1);
    assign w_behind_m1 = w_behind - ACK_W'(1);

    assign w_newer = w_s > w_top;
    assign w_equal = w_s == w_top;

    // Bit for the old highest after a forward shift, and bit for an older number.
    assign w_old_mark = t_window'(1) << w_ahead_m1[SH_W-1:0];
    assign w_mark     = t_window'(1) << w_behind_m1[SH_W-1:0];
    assign w_mark_hit = |(w_bits & w_mark);

    always_comb begin
        n_next_seq = w_cur_seq;
        n_highest  = w_top;
        n_bitmap   = w_bits;
        n_accepted = 1'b0;
        n_seq_out  = '0;
        unique case (r_action)
            ACT_SEND: begin
                n_seq_out = w_cur_seq;
                if (w_cur_seq != SEQ_MAX) begin
                    n_next_seq = w_cur_seq + SEQ_W'(1);
                end
            end
            ACT_RECEIVE: begin
                priority if (w_newer) begin
                    // A newer number moves the window forward.
                    if (w_ahead < ACK_W'(WINDOW)) begin
                        n_bitmap = w_bits << w_ahead[SH_W-1:0];
                        if (!w_top[ACK_W-1]) begin
                            n_bitmap = n_bitmap | w_old_mark;
                        end
                    end else begin
                        n_bitmap = '0;
                    end
                    n_highest  = w_s;
                    n_accepted = 1'b1;
                end else if (w_equal) begin
                    n_accepted = 1'b0;
                end else if (w_behind >= ACK_W'(WINDOW)) begin
                    n_accepted = 1'b0;
                end else if (w_mark_hit) begin
                    n_accepted = 1'b0;
                end else begin
                    n_bitmap   = w_bits | w_mark;
                    n_accepted = 1'b1;
                end
            end
            default: begin
                n_accepted = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_action   <= t_action'(i_action);
            r_endpoint <= i_endpoint;
            r_seq_in   <= i_seq_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENDPOINTS; i++) begin
                r_next_seq[i] <= '0;
                r_highest[i]  <= ACK_NONE;
                r_bitmap[i]   <= '0;
            end
        end else if (r_s1_valid && w_advance) begin
            r_next_seq[r_endpoint] <= n_next_seq;
            r_highest[r_endpoint]  <= n_highest;
            r_bitmap[r_endpoint]   <= n_bitmap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // A send reports the state before the request, a receive the state after.
    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_advance) begin
            r_seq_out  <= n_seq_out;
            r_ack_out  <= n_highest;
            r_ack_bits <= BITS_W'(n_bitmap);
            r_accepted <= n_accepted;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_seq_out      = r_seq_out;
    assign o_ack_out      = r_ack_out;
    assign o_ack_bits_out = r_ack_bits;
    assign o_accepted     = r_accepted;

endmodule

FILE: rtl/core/sarw_checker.sv
module sarw_checker
    import sarw_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic [SEQ_W-1:0]         o_seq_out,
    input logic signed [ACK_W-1:0]  o_ack_out,
    input logic                     o_accepted
);

    // Nothing is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown straight after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_seq_out)
            && $stable(o_ack_out) && $stable(o_accepted))
        else $error("stalled result changed");

    // Every accepted request must have a result on show after it has passed the input and output registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> ##1 o_out_valid)
        else $error("result missing two cycles after a request");

    // A stamped send with a nonzero number is never marked accepted.
    a_send_not_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_seq_out != '0) |-> !o_accepted)
        else $error("send result marked accepted");

    // An accepted receive always leaves a valid highest number.
    a_acc_highest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> !o_ack_out[ACK_W-1])
        else $error("accepted receive with nothing received");

endmodule

bind seq_ack_replay_window_core sarw_checker u_sarw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_seq_out   (o_seq_out),
    .o_ack_out   (o_ack_out),
    .o_accepted  (o_accepted)
);
